// ----- src/mpct_pkg.sv -----
// Shared types and constants for the mouse packet cursor tracker.
`default_nettype none
package mpct_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int VIS_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [7:0]       START_POS    = 8'd20;

  typedef enum logic [2:0] {
    EV_MOVE       = 3'd0,
    EV_LEFT_DOWN  = 3'd1,
    EV_LEFT_UP    = 3'd2,
    EV_RIGHT_DOWN = 3'd3,
    EV_RIGHT_UP   = 3'd4
  } event_kind_e;

  typedef enum logic [2:0] {
    PH_BUTTONS = 3'b001,
    PH_DX      = 3'b010,
    PH_DY      = 3'b100
  } phase_e;

  typedef struct packed {
    event_kind_e       ev;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy_raw;
  } pkt_t;

endpackage
`default_nettype wire

// ----- src/mpct_front.sv -----
// Byte framing: tracks packet phase and buttons, emits one packet record per packet.
`default_nettype none
module mpct_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mpct_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output mpct_pkg::pkt_t                   pkt_o
);

  mpct_pkg::phase_e            phase_q, phase_d;
  logic                        left_now_q, left_now_d;
  logic                        right_now_q, right_now_d;
  logic                        left_bef_q, left_bef_d;
  logic                        right_bef_q, right_bef_d;
  logic [mpct_pkg::BYTE_W-1:0] held_dx_q, held_dx_d;
  logic                        accept;
  mpct_pkg::event_kind_e       ev;

  // only the last byte of a packet needs room in the queue
  assign in_ready_o = (phase_q != mpct_pkg::PH_DY) || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (phase_q == mpct_pkg::PH_DY);

  always_comb begin
    priority if (right_bef_q && !right_now_q) begin
      ev = mpct_pkg::EV_RIGHT_UP;
    end else if (!right_bef_q && right_now_q) begin
      ev = mpct_pkg::EV_RIGHT_DOWN;
    end else if (left_bef_q && !left_now_q) begin
      ev = mpct_pkg::EV_LEFT_UP;
    end else if (!left_bef_q && left_now_q) begin
      ev = mpct_pkg::EV_LEFT_DOWN;
    end else begin
      ev = mpct_pkg::EV_MOVE;
    end
  end

  assign pkt_o = '{ev: ev, dx: held_dx_q, dy_raw: rx_byte_i};

  always_comb begin
    phase_d     = phase_q;
    left_now_d  = left_now_q;
    right_now_d = right_now_q;
    left_bef_d  = left_bef_q;
    right_bef_d = right_bef_q;
    held_dx_d   = held_dx_q;
    if (accept) begin
      unique case (phase_q)
        mpct_pkg::PH_DX: begin
          held_dx_d = rx_byte_i;
          phase_d   = mpct_pkg::PH_DY;
        end
        mpct_pkg::PH_DY: begin
          left_bef_d  = left_now_q;
          right_bef_d = right_now_q;
          left_now_d  = 1'b0;
          right_now_d = 1'b0;
          phase_d     = mpct_pkg::PH_BUTTONS;
        end
        default: begin
          // header byte: latch buttons, ignore sign and overflow bits
          left_now_d  = rx_byte_i[0];
          right_now_d = rx_byte_i[1];
          phase_d     = mpct_pkg::PH_DX;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mpct_pkg::PH_BUTTONS;
      left_now_q  <= 1'b0;
      right_now_q <= 1'b0;
      left_bef_q  <= 1'b0;
      right_bef_q <= 1'b0;
      held_dx_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      left_now_q  <= left_now_d;
      right_now_q <= right_now_d;
      left_bef_q  <= left_bef_d;
      right_bef_q <= right_bef_d;
      held_dx_q   <= held_dx_d;
    end
  end

`ifndef SYNTHESIS
  a_packet_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (phase_q == mpct_pkg::PH_BUTTONS && !left_now_q && !right_now_q))
    else $error("packet end did not return to header phase");
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("packet phase not one-hot");
  a_header_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != mpct_pkg::PH_DY) |-> in_ready_o)
    else $error("header or delta byte stalled");
`endif

endmodule
`default_nettype wire

// ----- src/mpct_fifo.sv -----
// Two-entry packet queue between the framing front and the cursor back end.
`default_nettype none
module mpct_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mpct_pkg::pkt_t pkt_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mpct_pkg::pkt_t      pkt_o
);

  mpct_pkg::pkt_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign pkt_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- src/mpct_back.sv -----
// Cursor update: applies deltas, clamps to screen, clips cursor size, registers result.
`default_nettype none
module mpct_back #(
  parameter int POS_BITS = 12,
  parameter int CURSOR_W = 16,
  parameter int CURSOR_H = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  wire mpct_pkg::pkt_t              pkt_i,
  output logic                             pop_o,
  input  wire logic [mpct_pkg::CFG_W-1:0]  screen_width_i,
  input  wire logic [mpct_pkg::CFG_W-1:0]  screen_height_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       event_kind_o,
  output logic [POS_BITS-1:0]              old_x_o,
  output logic [POS_BITS-1:0]              old_y_o,
  output logic [POS_BITS-1:0]              new_x_o,
  output logic [POS_BITS-1:0]              new_y_o,
  output logic signed [7:0]                move_dx_o,
  output logic signed [8:0]                move_dy_o,
  output logic [mpct_pkg::VIS_W-1:0]       visible_width_o,
  output logic [mpct_pkg::VIS_W-1:0]       visible_height_o
);

  localparam int LIM_W = POS_BITS + 1;
  localparam int CMP_W = (LIM_W > mpct_pkg::CFG_W) ? LIM_W : mpct_pkg::CFG_W;
  localparam int SUM_W = POS_BITS + 2;
  localparam int VIS_W = mpct_pkg::VIS_W;

  function automatic logic [LIM_W-1:0] eff_limit(input logic [mpct_pkg::CFG_W-1:0] size);
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] cap;
    logic [LIM_W-1:0] r;
    s   = CMP_W'(size);
    cap = CMP_W'(1) << POS_BITS;
    if (size == '0) begin
      r = LIM_W'(1);
    end else if (s > cap) begin
      r = LIM_W'(cap);
    end else begin
      r = LIM_W'(s);
    end
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                    input logic [LIM_W-1:0] lim);
    logic signed [SUM_W-1:0] top;
    logic [POS_BITS-1:0]     r;
    top = $signed({1'b0, lim}) - $signed(SUM_W'(1));
    if (v < 0) begin
      r = '0;
    end else if (v > top) begin
      r = top[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [VIS_W-1:0] visible(input logic [POS_BITS-1:0] pos,
                                               input logic [LIM_W-1:0] lim,
                                               input logic [LIM_W:0] size);
    logic [LIM_W:0]   edge_sum;
    logic [LIM_W-1:0] rest;
    logic [VIS_W-1:0] r;
    edge_sum = {2'b00, pos} + size;
    rest     = lim - {1'b0, pos};
    if (edge_sum >= {1'b0, lim}) begin
      r = rest[VIS_W-1:0];
    end else begin
      r = size[VIS_W-1:0];
    end
    return r;
  endfunction

  logic [POS_BITS-1:0]     cur_x_q, cur_x_d;
  logic [POS_BITS-1:0]     cur_y_q, cur_y_d;
  logic                    out_valid_q, out_valid_d;
  logic [LIM_W-1:0]        wlim, hlim;
  logic signed [8:0]       dy;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [POS_BITS-1:0]     nx, ny;

  logic [2:0]              ev_q;
  logic [POS_BITS-1:0]     old_x_q, old_y_q, new_x_q, new_y_q;
  logic signed [7:0]       dx_q;
  logic signed [8:0]       dy_q;
  logic [VIS_W-1:0]        vis_w_q, vis_h_q;

  // take a packet when the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    wlim  = eff_limit(screen_width_i);
    hlim  = eff_limit(screen_height_i);
    dy    = -$signed({pkt_i.dy_raw[7], pkt_i.dy_raw});
    sum_x = $signed({2'b00, cur_x_q}) + $signed({{(SUM_W-8){pkt_i.dx[7]}}, pkt_i.dx});
    sum_y = $signed({2'b00, cur_y_q}) + $signed({{(SUM_W-9){dy[8]}}, dy});
    nx    = clamp_pos(sum_x, wlim);
    ny    = clamp_pos(sum_y, hlim);
  end

  always_comb begin
    cur_x_d     = pop_o ? nx : cur_x_q;
    cur_y_d     = pop_o ? ny : cur_y_q;
    out_valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= POS_BITS'(mpct_pkg::START_POS);
      cur_y_q     <= POS_BITS'(mpct_pkg::START_POS);
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q    <= pkt_i.ev;
      old_x_q <= cur_x_q;
      old_y_q <= cur_y_q;
      new_x_q <= nx;
      new_y_q <= ny;
      dx_q    <= $signed(pkt_i.dx);
      dy_q    <= dy;
      vis_w_q <= visible(nx, wlim, (LIM_W+1)'(CURSOR_W));
      vis_h_q <= visible(ny, hlim, (LIM_W+1)'(CURSOR_H));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = ev_q;
  assign old_x_o          = old_x_q;
  assign old_y_o          = old_y_q;
  assign new_x_o          = new_x_q;
  assign new_y_o          = new_y_q;
  assign move_dx_o        = dx_q;
  assign move_dy_o        = dy_q;
  assign visible_width_o  = vis_w_q;
  assign visible_height_o = vis_h_q;

`ifndef SYNTHESIS
  a_cursor_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (cur_x_q == new_x_q && cur_y_q == new_y_q))
    else $error("cursor state differs from reported position");
  a_old_is_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (old_x_q == $past(cur_x_q) && old_y_q == $past(cur_y_q)))
    else $error("old position not taken from cursor state");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(event_kind_o) && $stable(new_x_o) && $stable(new_y_o)))
    else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

// ----- src/mouse_packet_cursor_tracker_core.sv -----
// After the third byte is accepted, a result passes the packet queue and then the
// output register. Throughput: one byte per cycle; a last byte waits for room in
// the two-entry packet queue, and the back end retires one packet per cycle while
// its output register is free or drained. Reset: cursor at column 20, row 20,
// screen 640 x 480, byte phase at the header, buttons released; no clearing pass.
`default_nettype none
module mouse_packet_cursor_tracker_core #(
  parameter int CURSOR_W = 16,
  parameter int CURSOR_H = 16,
  parameter int POS_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mpct_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mpct_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [mpct_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [2:0]                           event_kind_o,
  output logic [POS_BITS-1:0]                  old_x_o,
  output logic [POS_BITS-1:0]                  old_y_o,
  output logic [POS_BITS-1:0]                  new_x_o,
  output logic [POS_BITS-1:0]                  new_y_o,
  output logic signed [7:0]                    move_dx_o,
  output logic signed [8:0]                    move_dy_o,
  output logic [mpct_pkg::VIS_W-1:0]           visible_width_o,
  output logic [mpct_pkg::VIS_W-1:0]           visible_height_o
);

  logic [mpct_pkg::CFG_W-1:0] width_q, width_d;
  logic [mpct_pkg::CFG_W-1:0] height_q, height_d;
  logic                       cfg_write;

  logic           push, full, pop, empty;
  mpct_pkg::pkt_t front_pkt, queue_pkt;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        mpct_pkg::REG_SCREEN_WIDTH:  width_d  = cfg_data_i;
        mpct_pkg::REG_SCREEN_HEIGHT: height_d = cfg_data_i;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpct_pkg::WIDTH_RESET;
      height_q <= mpct_pkg::HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  mpct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .pkt_o      (front_pkt)
  );

  mpct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (front_pkt),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .pkt_o   (queue_pkt)
  );

  mpct_back #(
    .POS_BITS (POS_BITS),
    .CURSOR_W (CURSOR_W),
    .CURSOR_H (CURSOR_H)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .pkt_i            (queue_pkt),
    .pop_o            (pop),
    .screen_width_i   (width_q),
    .screen_height_i  (height_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .old_x_o          (old_x_o),
    .old_y_o          (old_y_o),
    .new_x_o          (new_x_o),
    .new_y_o          (new_y_o),
    .move_dx_o        (move_dx_o),
    .move_dy_o        (move_dy_o),
    .visible_width_o  (visible_width_o),
    .visible_height_o (visible_height_o)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the mouse packet cursor tracker core.
`timescale 1ns / 100ps
module tb_top;

  localparam int POS_BITS      = 12;
  localparam int CURSOR_W      = 16;
  localparam int CURSOR_H      = 16;
  localparam int SCREEN_CAP    = 1 << POS_BITS;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 10;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 175;
  localparam int PAUSE_AT      = 90;

  localparam logic [mpct_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [mpct_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    mpct_pkg::event_kind_e ev;
    logic [11:0]           old_x;
    logic [11:0]           old_y;
    logic [11:0]           new_x;
    logic [11:0]           new_y;
    logic signed [7:0]     dx;
    logic signed [8:0]     dy;
    logic [4:0]            vis_w;
    logic [4:0]            vis_h;
  } cursor_report_t;

  typedef struct {
    bit                             is_cfg;
    logic [mpct_pkg::CFG_IDX_W-1:0] idx;
    logic [mpct_pkg::CFG_W-1:0]     data;
    logic [mpct_pkg::BYTE_W-1:0]    rx;
    bit                             typed;
    cursor_report_t                 want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mpct_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [mpct_pkg::BYTE_W-1:0] rx_byte = '0;
  logic out_ready = 1'b0;

  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic [2:0] event_kind_o;
  logic [POS_BITS-1:0] old_x_o, old_y_o, new_x_o, new_y_o;
  logic signed [7:0] move_dx_o;
  logic signed [8:0] move_dy_o;
  logic [mpct_pkg::VIS_W-1:0] visible_width_o, visible_height_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  cursor_report_t expected_reports[$];
  script_row_t packet_script[$];

  logic [mpct_pkg::CFG_W-1:0] phase_w [PHASES] =
    '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd17, 13'd0};
  logic [mpct_pkg::CFG_W-1:0] phase_h [PHASES] =
    '{13'd480, 13'd1, 13'd4096, 13'd0, 13'd4000, 13'd0};

  // Tracker model state
  mpct_pkg::phase_e           trk_phase = mpct_pkg::PH_BUTTONS;
  logic                       left_cur = 1'b0, right_cur = 1'b0;
  logic                       left_prev = 1'b0, right_prev = 1'b0;
  logic [7:0]                 dx_hold = '0;
  logic [11:0]                cur_col = 12'(mpct_pkg::START_POS);
  logic [11:0]                cur_row = 12'(mpct_pkg::START_POS);
  logic [mpct_pkg::CFG_W-1:0] scr_w = mpct_pkg::WIDTH_RESET;
  logic [mpct_pkg::CFG_W-1:0] scr_h = mpct_pkg::HEIGHT_RESET;

  mouse_packet_cursor_tracker_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .event_kind_o     (event_kind_o),
    .old_x_o          (old_x_o),
    .old_y_o          (old_y_o),
    .new_x_o          (new_x_o),
    .new_y_o          (new_y_o),
    .move_dx_o        (move_dx_o),
    .move_dy_o        (move_dy_o),
    .visible_width_o  (visible_width_o),
    .visible_height_o (visible_height_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int screen_limit(input logic [mpct_pkg::CFG_W-1:0] size);
    if (size == 0) return 1;
    if (int'(size) > SCREEN_CAP) return SCREEN_CAP;
    return int'(size);
  endfunction

  function automatic int clamp_coord(input int v, input int lim);
    if (v < 0) v = 0;
    if (v > lim - 1) v = lim - 1;
    return v;
  endfunction

  function automatic logic [4:0] visible_span(input int pos, input int lim, input int size);
    int span;
    span = (pos + size >= lim) ? lim - pos : size;
    return span[4:0];
  endfunction

  // Advance the tracker by one byte; return 1 when the byte completes a packet.
  function automatic bit track_byte(input logic [7:0] b, output cursor_report_t rep);
    int wlim, hlim, dx, dy, nx, ny;
    mpct_pkg::event_kind_e ev;
    rep = '0;
    if (trk_phase == mpct_pkg::PH_DX) begin
      dx_hold = b;
      trk_phase = mpct_pkg::PH_DY;
      return 1'b0;
    end
    if (trk_phase != mpct_pkg::PH_DY) begin
      left_cur = b[0];
      right_cur = b[1];
      trk_phase = mpct_pkg::PH_DX;
      return 1'b0;
    end
    wlim = screen_limit(scr_w);
    hlim = screen_limit(scr_h);
    dx = int'($signed(dx_hold));
    dy = -int'($signed(b));
    nx = clamp_coord(int'(cur_col) + dx, wlim);
    ny = clamp_coord(int'(cur_row) + dy, hlim);
    ev = mpct_pkg::EV_MOVE;
    if (!left_prev && left_cur) ev = mpct_pkg::EV_LEFT_DOWN;
    if (left_prev && !left_cur) ev = mpct_pkg::EV_LEFT_UP;
    if (!right_prev && right_cur) ev = mpct_pkg::EV_RIGHT_DOWN;
    if (right_prev && !right_cur) ev = mpct_pkg::EV_RIGHT_UP;
    rep.ev = ev;
    rep.old_x = cur_col;
    rep.old_y = cur_row;
    rep.new_x = nx[11:0];
    rep.new_y = ny[11:0];
    rep.dx = dx[7:0];
    rep.dy = dy[8:0];
    rep.vis_w = visible_span(nx, wlim, CURSOR_W);
    rep.vis_h = visible_span(ny, hlim, CURSOR_H);
    cur_col = nx[11:0];
    cur_row = ny[11:0];
    left_prev = left_cur;
    right_prev = right_cur;
    left_cur = 1'b0;
    right_cur = 1'b0;
    trk_phase = mpct_pkg::PH_BUTTONS;
    return 1'b1;
  endfunction

  // Hold the byte until accepted, then queue what the packet should report.
  task automatic push_byte(input logic [7:0] b, input bit typed, input cursor_report_t want);
    cursor_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(negedge clk); while (!in_ready_o);
    @(posedge clk);
    if (track_byte(b, rep)) expected_reports.push_back(typed ? want : rep);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mpct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpct_pkg::CFG_W-1:0] data);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready_o);
    @(posedge clk);
    case (idx)
      mpct_pkg::REG_SCREEN_WIDTH:  scr_w = data;
      mpct_pkg::REG_SCREEN_HEIGHT: scr_h = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(negedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin : report_check
    cursor_report_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, event %0d", $time, event_kind_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("event_kind", want.ev, event_kind_o);
        check_field("old_x", want.old_x, old_x_o);
        check_field("old_y", want.old_y, old_y_o);
        check_field("new_x", want.new_x, new_x_o);
        check_field("new_y", want.new_y, new_y_o);
        check_field("move_dx", want.dx, move_dx_o);
        check_field("move_dy", want.dy, move_dy_o);
        check_field("visible_width", want.vis_w, visible_width_o);
        check_field("visible_height", want.vis_h, visible_height_o);
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    cursor_report_t none;
    logic [7:0] b;
    bit drift;
    int p, n, r;
    none = '0;
    drift = 1'b0;

    // Extremes of the deltas and every button transition from reset
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 1,
      '{mpct_pkg::EV_MOVE, 12'd20, 12'd20, 12'd20, 12'd20,
        8'h00, 9'h000, 5'd16, 5'd16}});
    packet_script.push_back('{0, '0, '0, 8'h01, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h7F, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h80, 1,
      '{mpct_pkg::EV_LEFT_DOWN, 12'd20, 12'd20, 12'd147, 12'd148,
        8'h7F, 9'h080, 5'd16, 5'd16}});
    packet_script.push_back('{0, '0, '0, 8'h02, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h80, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h7F, 1,
      '{mpct_pkg::EV_RIGHT_DOWN, 12'd147, 12'd148, 12'd19, 12'd21,
        8'h80, 9'h181, 5'd16, 5'd16}});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h80, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h7F, 1,
      '{mpct_pkg::EV_RIGHT_UP, 12'd19, 12'd21, 12'd0, 12'd0,
        8'h80, 9'h181, 5'd16, 5'd16}});
    // Both buttons pressed together, then held
    packet_script.push_back('{0, '0, '0, 8'hFF, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h01, 0, none});
    packet_script.push_back('{0, '0, '0, 8'hFF, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h03, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    // Zero width, oversized height, write to an unused index
    packet_script.push_back('{1, mpct_pkg::REG_SCREEN_WIDTH, 13'd0, '0, 0, none});
    packet_script.push_back('{1, mpct_pkg::REG_SCREEN_HEIGHT, 13'h1FFF, '0, 0, none});
    packet_script.push_back('{1, REG_SPARE_2, 13'h1FFF, '0, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h7F, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h80, 0, none});
    // Shrink the height under the cursor: old row stays stale
    packet_script.push_back('{1, mpct_pkg::REG_SCREEN_WIDTH, 13'd4096, '0, 0, none});
    packet_script.push_back('{1, mpct_pkg::REG_SCREEN_HEIGHT, 13'd1, '0, 0, none});
    packet_script.push_back('{1, REG_SPARE_3, 13'd0, '0, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h02, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h80, 0, none});
    packet_script.push_back('{0, '0, '0, 8'h00, 0, none});

    send_idle_pct = 26;
    recv_idle_pct = 65;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (packet_script[i]) begin
      row = packet_script[i];
      if (row.is_cfg) write_reg(row.idx, row.data);
      else push_byte(row.rx, row.typed, row.want);
    end

    for (p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 2) ? 26 : (p < 4) ? 65 : 0;
      recv_idle_pct = (p < 2) ? 65 : (p < 4) ? 26 : 0;
      if (p == PHASES - 1) begin
        phase_w[p] = 13'($urandom_range(8191));
        phase_h[p] = 13'($urandom_range(8191));
      end
      write_reg(mpct_pkg::REG_SCREEN_WIDTH, phase_w[p]);
      write_reg(mpct_pkg::REG_SCREEN_HEIGHT, phase_h[p]);
      write_reg(($urandom_range(1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 13'($urandom));
      for (n = 0; n < PHASE_BYTES; n++) begin
        if (n == PAUSE_AT) drain_reports();
        if (trk_phase == mpct_pkg::PH_BUTTONS) begin
          if ($urandom_range(29) == 0) drift = ~drift;
        end
        if (trk_phase == mpct_pkg::PH_BUTTONS) begin
          b = 8'($urandom);
        end else begin
          // Drift steers the cursor into the screen edges
          r = $urandom_range(9);
          case (r)
            0, 1, 2: b = drift ? 8'h7F : 8'h80;
            3:       b = 8'h00;
            4:       b = drift ? 8'hFF : 8'h01;
            default: b = 8'($urandom);
          endcase
        end
        push_byte(b, 1'b0, none);
      end
    end

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mpct_pkg.sv
src/mpct_front.sv
src/mpct_fifo.sv
src/mpct_back.sv
src/mouse_packet_cursor_tracker_core.sv
tb/sv/tb_top.sv
